// ===== hw/rtl/zvis_pkg.sv =====
// ----------------------------------------------------------------------------
// zvis_pkg
// Shared widths, register indexes and the ring access type for the
// zero-vibration input shaper.
// ----------------------------------------------------------------------------
package zvis_pkg;

    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int LEN_W      = RING_AW + 1;
    localparam int DELAY_W    = 8;
    localparam int CMP_W      = (DELAY_W > LEN_W) ? DELAY_W : LEN_W;

    localparam int CMD_W      = 32;
    localparam int POS_W      = 48;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = COEF_W + 1 + CMD_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int FRAC_SHIFT = 15;
    localparam int RND_W      = SUM_W - FRAC_SHIFT;
    localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_DIRECT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_DELAYED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMPULSE_GAP  = 2'd2;

    localparam logic REQ_SHAPE = 1'b0;
    localparam logic REQ_STOP  = 1'b1;

    localparam logic [COEF_W-1:0]  COEF_RESET  = 16'd16384;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd1;

    typedef struct packed {
        logic               clear;
        logic               wr_en;
        logic [RING_AW-1:0] wr_addr;
        logic [CMD_W-1:0]   wr_data;
        logic               rd_en;
        logic [RING_AW-1:0] rd_addr;
    } ring_req_t;

endpackage

// ===== hw/rtl/zv_input_shaper_top.sv =====
// ----------------------------------------------------------------------------
// zv_input_shaper_top
// Two-impulse zero-vibration shaper for an axis position command.
// ----------------------------------------------------------------------------
// The shaper takes one request per clock while the output is not stalled
// and returns one result per request, in order; each result is registered
// in stage 1, stage 2, stage 3 and the output stage before it is presented.
// Request stage: the command delta is formed and saturated, written to the
// delta ring, and the delayed delta is read (registered read). Then the two
// unsigned Q1.15 gains multiply, the Q.15 sum is rounded to Q.0, and the
// 48-bit shaped position accumulates in the output stage, which sets the
// one-request-per-cycle rate. Reset and writes to the impulse gap register
// clear the ring at once (per-entry valid bits); there is no clearing pass.
// Coefficients and delay must be written only while no request is in
// flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module zv_input_shaper_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_we,
    input  logic [zvis_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [zvis_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // request channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,  // [31:0] cmd_pos
    input  logic                               s_tuser,  // [0] req_type
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [47:0]                        m_tdata,  // [47:0] shaped_pos
    output logic                               m_tuser   // [0] saturated
);

    localparam int AW = zvis_pkg::RING_AW;
    localparam int CW = zvis_pkg::CMD_W;
    localparam int PW = zvis_pkg::POS_W;

    // configuration registers
    logic [zvis_pkg::COEF_W-1:0]  coef_direct_reg;
    logic [zvis_pkg::COEF_W-1:0]  coef_delayed_reg;
    logic [zvis_pkg::DELAY_W-1:0] impulse_gap_reg;

    // request-stage state
    logic [AW-1:0]        head_reg;
    logic [AW-1:0]        head_next;
    logic signed [CW-1:0] last_cmd_reg;

    // pipeline
    logic                 v1_reg, v2_reg, v3_reg;
    logic                 stop1_reg, stop2_reg, stop3_reg;
    logic                 dsat1_reg, dsat2_reg, sat3_reg;
    logic signed [CW-1:0] delta1_reg;
    logic signed [zvis_pkg::PROD_W-1:0] prod_a_reg, prod_b_reg;
    logic signed [zvis_pkg::PROD_W-1:0] prod_a_next, prod_b_next;
    logic signed [zvis_pkg::RND_W-1:0]  rnd3_reg;
    logic signed [zvis_pkg::RND_W-1:0]  rnd3_next;
    logic signed [PW-1:0] accum_reg;
    logic signed [PW-1:0] accum_next;
    logic                 acc_sat;

    logic                 m_tvalid_reg;
    logic [PW-1:0]        m_tdata_reg;
    logic                 m_tuser_reg;

    logic rdy_out, rdy3, rdy2, rdy1, in_fire, is_stop;

    // delta
    logic signed [CW:0]   diff;
    logic signed [CW-1:0] delta;
    logic                 delta_sat;

    // ring addressing
    logic [zvis_pkg::CMP_W-1:0] delay_ext, eff_delay;
    logic [zvis_pkg::LEN_W-1:0] ring_len, head_inc;
    logic [AW-1:0]              rd_addr;
    zvis_pkg::ring_req_t        ring_req;
    logic [CW-1:0]              ring_rd_data;

    // rounding and accumulate
    logic signed [zvis_pkg::SUM_W-1:0] sum, sum_biased;
    logic signed [PW:0]                acc_wide;
    logic [PW-1:0]                     result;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign rdy_out  = !m_tvalid_reg || m_tready;
    assign rdy3     = !v3_reg || rdy_out;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign in_fire  = s_tvalid && rdy1;
    assign is_stop  = (s_tuser == zvis_pkg::REQ_STOP);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_direct_reg  <= zvis_pkg::COEF_RESET;
            coef_delayed_reg <= zvis_pkg::COEF_RESET;
            impulse_gap_reg  <= zvis_pkg::DELAY_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                zvis_pkg::REG_COEF_DIRECT:  coef_direct_reg  <= cfg_wdata;
                zvis_pkg::REG_COEF_DELAYED: coef_delayed_reg <= cfg_wdata;
                zvis_pkg::REG_IMPULSE_GAP:
                    impulse_gap_reg <= cfg_wdata[zvis_pkg::DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request stage: delta, ring addresses
    // ------------------------------------------------------------------
    always_comb begin
        diff      = {s_tdata[CW-1], s_tdata} - {last_cmd_reg[CW-1], last_cmd_reg};
        delta_sat = (diff[CW] != diff[CW-1]);
        if (delta_sat) begin
            delta = diff[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            delta = diff[CW-1:0];
        end
    end

    always_comb begin
        delay_ext = zvis_pkg::CMP_W'(impulse_gap_reg);
        eff_delay = delay_ext;
        if (delay_ext == '0) begin
            eff_delay = zvis_pkg::CMP_W'(1);
        end
        if (delay_ext > zvis_pkg::CMP_W'(zvis_pkg::RING_DEPTH - 1)) begin
            eff_delay = zvis_pkg::CMP_W'(zvis_pkg::RING_DEPTH - 1);
        end
        ring_len = eff_delay[zvis_pkg::LEN_W-1:0] + zvis_pkg::LEN_W'(1);
        head_inc = {1'b0, head_reg} + zvis_pkg::LEN_W'(1);
        // delayed entry sits just after the head
        rd_addr  = (head_inc == ring_len) ? '0 : head_inc[AW-1:0];
        head_next = rd_addr;
    end

    always_comb begin
        ring_req.clear   = cfg_we && (cfg_index == zvis_pkg::REG_IMPULSE_GAP);
        ring_req.wr_en   = in_fire && !is_stop;
        ring_req.wr_addr = head_reg;
        ring_req.wr_data = delta;
        ring_req.rd_en   = in_fire;
        ring_req.rd_addr = rd_addr;
    end

    zvis_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ring_req),
        .rd_data (ring_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            last_cmd_reg <= '0;
        end else if (ring_req.clear) begin
            head_reg <= '0;
        end else if (in_fire) begin
            if (is_stop) begin
                last_cmd_reg <= '0;
            end else begin
                last_cmd_reg <= s_tdata;
                head_reg     <= head_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1 -> 2: multiply both impulses
    // ------------------------------------------------------------------
    always_comb begin
        prod_a_next = $signed({1'b0, coef_direct_reg}) * delta1_reg;
        prod_b_next = $signed({1'b0, coef_delayed_reg}) * $signed(ring_rd_data);
    end

    // ------------------------------------------------------------------
    // stage 2 -> 3: sum and round Q.15 to Q.0, halves upward
    // ------------------------------------------------------------------
    always_comb begin
        sum        = {prod_a_reg[zvis_pkg::PROD_W-1], prod_a_reg}
                   + {prod_b_reg[zvis_pkg::PROD_W-1], prod_b_reg};
        sum_biased = sum + zvis_pkg::SUM_W'(zvis_pkg::ROUND_BIAS);
        rnd3_next  = sum_biased[zvis_pkg::SUM_W-1:zvis_pkg::FRAC_SHIFT];
    end

    // ------------------------------------------------------------------
    // stage 3 -> out: accumulate with saturation
    // ------------------------------------------------------------------
    always_comb begin
        acc_wide = {accum_reg[PW-1], accum_reg}
                 + {{(PW + 1 - zvis_pkg::RND_W){rnd3_reg[zvis_pkg::RND_W-1]}}, rnd3_reg};
        acc_sat  = (acc_wide[PW] != acc_wide[PW-1]);
        if (acc_sat) begin
            result = acc_wide[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end else begin
            result = acc_wide[PW-1:0];
        end
        accum_next = stop3_reg ? '0 : result;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            accum_reg    <= '0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_fire;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy_out) begin
                m_tvalid_reg <= v3_reg;
                if (v3_reg) begin
                    accum_reg <= accum_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            stop1_reg  <= is_stop;
            dsat1_reg  <= delta_sat;
            delta1_reg <= delta;
        end
        if (rdy2 && v1_reg) begin
            stop2_reg  <= stop1_reg;
            dsat2_reg  <= dsat1_reg;
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
        if (rdy3 && v2_reg) begin
            stop3_reg <= stop2_reg;
            sat3_reg  <= dsat2_reg;
            rnd3_reg  <= rnd3_next;
        end
        if (rdy_out && v3_reg) begin
            m_tdata_reg <= accum_next;
            m_tuser_reg <= !stop3_reg && (sat3_reg || acc_sat);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hw/rtl/zvis_ring.sv =====
// ----------------------------------------------------------------------------
// zvis_ring
// Delta ring: synchronous memory with a write port and a registered read port,
// plus one valid bit per entry so that a clear takes effect at once.
// ----------------------------------------------------------------------------
module zvis_ring (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  zvis_pkg::ring_req_t            req,
    output logic [zvis_pkg::CMD_W-1:0]     rd_data
);

    logic [zvis_pkg::CMD_W-1:0]      mem_reg [zvis_pkg::RING_DEPTH];
    logic [zvis_pkg::RING_DEPTH-1:0] valid_reg;
    logic [zvis_pkg::CMD_W-1:0]      rd_data_reg;
    logic                            rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem_reg[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hw/rtl/zvis_checker.sv =====
// ----------------------------------------------------------------------------
// zvis_checker
// Port-level checks on the shaper, attached to the top level by bind.
// ----------------------------------------------------------------------------
module zvis_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [47:0]                     m_tdata,
    input logic                            m_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // empty output register means the request side is open
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request blocked with empty output");

    // reset drops the result channel
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a presented result carries fully defined fields
    a_result_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !$isunknown({m_tdata, m_tuser}))
        else $error("unknown result fields");

    // request side never shows an undefined valid once out of reset
    a_valid_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown(s_tvalid))
        else $error("unknown request valid");

endmodule

bind zv_input_shaper_top zvis_checker u_zvis_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-impulse zero-vibration shaper. A local
// fixed-point predictor follows every accepted request, and the result
// checker compares each returned shaped position and saturation flag in
// order. Directed edges, gain and delay settings, output back-pressure,
// random command streams and full-scale command swings are exercised.
// ----------------------------------------------------------------------------
module tb;

    localparam int     LIMIT_CYCLES    = 200000;
    localparam int     DRAIN_CYCLES    = 8;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     SWING_TRIPLES   = 8;
    localparam longint DELTA_MAX       = 64'sd2147483647;
    localparam longint DELTA_MIN       = -64'sd2147483648;
    localparam longint POS_MAX         = (64'sd1 <<< 47) - 1;
    localparam longint POS_MIN         = -(64'sd1 <<< 47);
    localparam longint ROUND_HALF      = 64'sd16384;

    localparam logic [zvis_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [zvis_pkg::POS_W-1:0] pos;
        logic                       sat;
    } shaped_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [zvis_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [zvis_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [31:0]                     s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [47:0]                     m_tdata;
    logic                            m_tuser;

    // predictor state
    logic [zvis_pkg::COEF_W-1:0]       gain_direct;
    logic [zvis_pkg::COEF_W-1:0]       gain_delayed;
    logic [zvis_pkg::DELAY_W-1:0]      delay_reg;
    logic signed [zvis_pkg::CMD_W-1:0] delta_hist [zvis_pkg::RING_DEPTH];
    int                                hist_head;
    logic signed [zvis_pkg::CMD_W-1:0] prev_command;
    longint                            shaped_total;

    shaped_t pending_positions [$];

    int snd_gap_max  = 13;
    int rcv_stall_max = 13;
    bit hold_off_req = 1'b0;
    logic signed [31:0] walk_pos = '0;

    int mismatch_count = 0;
    int sent_count     = 0;
    int result_count   = 0;
    int sat_count      = 0;
    int cfg_count      = 0;

    always #1 aclk = ~aclk;

    zv_input_shaper_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [31:0] cmd_pos
        .s_tuser   (s_tuser),   // [0] req_type
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [47:0] shaped_pos
        .m_tuser   (m_tuser)    // [0] saturated
    );

    function automatic void clear_history();
        for (int i = 0; i < zvis_pkg::RING_DEPTH; i++) delta_hist[i] = '0;
        hist_head = 0;
    endfunction

    function automatic void reset_shaper_state();
        gain_direct  = zvis_pkg::COEF_RESET;
        gain_delayed = zvis_pkg::COEF_RESET;
        delay_reg    = zvis_pkg::DELAY_RESET;
        clear_history();
        prev_command = '0;
        shaped_total = 0;
    endfunction

    // Shape one request and advance the predictor state.
    function automatic shaped_t shape_sample(logic kind, logic [31:0] cmd_bits);
        shaped_t r;
        longint  cmd;
        longint  delta;
        longint  delayed;
        longint  sum;
        longint  acc;
        int      span;
        int      len;
        int      rd;
        r.sat = 1'b0;
        r.pos = '0;
        if (kind == zvis_pkg::REQ_STOP) begin
            shaped_total = 0;
            prev_command = '0;
            return r;
        end
        cmd   = longint'($signed(cmd_bits));
        delta = cmd - longint'(prev_command);
        if (delta > DELTA_MAX) begin
            delta = DELTA_MAX;
            r.sat = 1'b1;
        end else if (delta < DELTA_MIN) begin
            delta = DELTA_MIN;
            r.sat = 1'b1;
        end
        prev_command = $signed(cmd_bits);

        span = int'(delay_reg);
        if (span == 0) span = 1;
        if (span > zvis_pkg::RING_DEPTH - 1) span = zvis_pkg::RING_DEPTH - 1;
        len = span + 1;
        if (hist_head >= len) hist_head = 0;
        rd = (hist_head + 1 == len) ? 0 : hist_head + 1;
        delayed = longint'(delta_hist[rd]);

        sum = longint'(gain_direct) * delta + longint'(gain_delayed) * delayed;
        acc = shaped_total + ((sum + ROUND_HALF) >>> 15);
        if (acc > POS_MAX) begin
            acc   = POS_MAX;
            r.sat = 1'b1;
        end else if (acc < POS_MIN) begin
            acc   = POS_MIN;
            r.sat = 1'b1;
        end
        shaped_total = acc;

        delta_hist[hist_head] = delta[31:0];
        hist_head = (hist_head + 1 == len) ? 0 : hist_head + 1;
        r.pos = acc[zvis_pkg::POS_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH result %0d: %s", result_count, msg);
        mismatch_count++;
    endtask

    // Send one request; valid stays high on return so back-to-back items flow.
    task automatic send_request(input logic kind, input logic [31:0] cmd);
        int gap;
        gap = $urandom_range(0, snd_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= cmd;
        do @(posedge aclk); while (!s_tready);
        pending_positions.push_back(shape_sample(kind, cmd));
        sent_count++;
    endtask

    // Drop valid, then wait for every expected result and the pipeline tail.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [zvis_pkg::CFG_IDX_W-1:0] idx,
                             input logic [zvis_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            zvis_pkg::REG_COEF_DIRECT:  gain_direct  = data;
            zvis_pkg::REG_COEF_DELAYED: gain_delayed = data;
            zvis_pkg::REG_IMPULSE_GAP: begin
                delay_reg = data[zvis_pkg::DELAY_W-1:0];
                clear_history();
            end
            default: ;
        endcase
        cfg_count++;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [15:0] a0, input logic [15:0] a1,
                                  input logic [15:0] dly_word);
        quiesce();
        write_reg(zvis_pkg::REG_COEF_DIRECT, a0);
        write_reg(zvis_pkg::REG_COEF_DELAYED, a1);
        write_reg(zvis_pkg::REG_IMPULSE_GAP, dly_word);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'hFFFF;
            3:       return 16'd16384;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_delay_word();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 4))
            0:       w[7:0] = 8'd0;
            1:       w[7:0] = 8'd1;
            2:       w[7:0] = 8'd255;
            3:       w[7:0] = 8'($urandom_range(2, 8));
            default: w[7:0] = 8'($urandom_range(2, 254));
        endcase
        return w;
    endfunction

    // Mostly smooth motion, with jumps, extremes and the odd stop.
    task automatic send_random_item();
        logic [31:0] cmd;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            walk_pos = '0;
            send_request(zvis_pkg::REQ_STOP, 32'($urandom));
            return;
        end
        if (pick < 60)
            cmd = walk_pos + 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        else if (pick < 75)
            cmd = 32'($urandom);
        else if (pick < 85)
            case ($urandom_range(0, 4))
                0:       cmd = 32'h7FFF_FFFF;
                1:       cmd = 32'h8000_0000;
                2:       cmd = 32'h0000_0000;
                3:       cmd = 32'hFFFF_FFFF;
                default: cmd = 32'h0000_0001;
            endcase
        else
            cmd = walk_pos + 32'($urandom);
        walk_pos = cmd;
        send_request(zvis_pkg::REQ_SHAPE, cmd);
    endtask

    task automatic test_directed();
        send_request(zvis_pkg::REQ_SHAPE, 32'h0000_0000);
        send_request(zvis_pkg::REQ_SHAPE, 32'h0000_0001);
        send_request(zvis_pkg::REQ_SHAPE, 32'hFFFF_FFFF);
        send_request(zvis_pkg::REQ_SHAPE, 32'h0000_8000);
        send_request(zvis_pkg::REQ_SHAPE, 32'h7FFF_FFFF);
        // full-scale swings saturate the delta both ways
        send_request(zvis_pkg::REQ_SHAPE, 32'h8000_0000);
        send_request(zvis_pkg::REQ_SHAPE, 32'h7FFF_FFFF);
        send_request(zvis_pkg::REQ_SHAPE, 32'hFFFF_FFFF);
        send_request(zvis_pkg::REQ_STOP,  32'hDEAD_BEEF);
        send_request(zvis_pkg::REQ_STOP,  32'hFFFF_FFFF);
        send_request(zvis_pkg::REQ_SHAPE, 32'h1234_5678);
        send_request(zvis_pkg::REQ_SHAPE, 32'hEDCB_A988);
        send_request(zvis_pkg::REQ_SHAPE, 32'h8000_0000);
        send_request(zvis_pkg::REQ_STOP,  32'h0000_0000);
        send_request(zvis_pkg::REQ_SHAPE, 32'h5555_5555);
        send_request(zvis_pkg::REQ_SHAPE, 32'hAAAA_AAAA);
        send_request(zvis_pkg::REQ_SHAPE, 32'h0000_0000);
        send_request(zvis_pkg::REQ_SHAPE, 32'h0000_0003);
        walk_pos = 32'h0000_0003;
    endtask

    task automatic test_coefficients();
        logic [15:0] a0 [5] = '{16'd0, 16'd32768, 16'd0, 16'hFFFF, 16'd32768};
        logic [15:0] a1 [5] = '{16'd0, 16'd0, 16'd32768, 16'hFFFF, 16'd32768};
        for (int p = 0; p < 5; p++) begin
            apply_settings(a0[p], a1[p], 16'd3);
            repeat (16) send_random_item();
        end
        // a write to an unused index must leave everything as it was
        quiesce();
        write_reg(REG_UNUSED, 16'hFFFF);
        repeat (16) send_random_item();
    endtask

    task automatic test_delay_range();
        // delay zero acts as one; upper data bits are ignored
        apply_settings(16'd20000, 16'd12768, 16'hFF00);
        repeat (24) send_random_item();
        apply_settings(16'd16384, 16'd16384, 16'h00FF);
        repeat (300) send_random_item();
        apply_settings(16'd24000, 16'd8768, 16'h5A02);
        repeat (24) send_random_item();
    endtask

    task automatic test_input_pressure();
        int saved_gap;
        saved_gap   = snd_gap_max;
        snd_gap_max = 0;
        hold_off_req = 1'b1;
        repeat (80) send_random_item();
        snd_gap_max = saved_gap;
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 5; p++) begin
            apply_settings(pick_gain(), pick_gain(), pick_delay_word());
            snd_gap_max   = (p % 3 == 2) ? 0 : 13;
            rcv_stall_max = (p % 3 == 1) ? 0 : 13;
            repeat (90) send_random_item();
        end
        snd_gap_max   = 13;
        rcv_stall_max = 13;
    endtask

    // Full-scale command cycles at maximum gains, saturating the delta at each jump between the two extremes.
    task automatic test_full_scale_swings();
        quiesce();
        snd_gap_max   = 0;
        rcv_stall_max = 0;
        apply_settings(16'hFFFF, 16'hFFFF, 16'd1);
        send_request(zvis_pkg::REQ_STOP, 32'h0);
        repeat (SWING_TRIPLES) begin
            send_request(zvis_pkg::REQ_SHAPE, 32'h0000_0000);
            send_request(zvis_pkg::REQ_SHAPE, 32'h7FFF_FFFF);
            send_request(zvis_pkg::REQ_SHAPE, 32'h8000_0000);
        end
        send_request(zvis_pkg::REQ_STOP, 32'h0);
        repeat (SWING_TRIPLES) begin
            send_request(zvis_pkg::REQ_SHAPE, 32'h0000_0000);
            send_request(zvis_pkg::REQ_SHAPE, 32'h8000_0000);
            send_request(zvis_pkg::REQ_SHAPE, 32'h7FFF_FFFF);
        end
        send_request(zvis_pkg::REQ_STOP, 32'h0);
        snd_gap_max   = 13;
        rcv_stall_max = 13;
    endtask

    initial begin : result_checker
        int      stall;
        shaped_t want;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                stall = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                stall = $urandom_range(0, rcv_stall_max);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (pending_positions.size() == 0) begin
                report_mismatch($sformatf("unexpected result pos=%h sat=%b",
                                          m_tdata, m_tuser));
            end else begin
                want = pending_positions.pop_front();
                if (m_tdata !== want.pos)
                    report_mismatch($sformatf("shaped_pos %h, want %h", m_tdata, want.pos));
                if (m_tuser !== want.sat)
                    report_mismatch($sformatf("saturated %b, want %b", m_tuser, want.sat));
                if (want.sat) sat_count++;
            end
            result_count++;
        end
    end

    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("timeout with %0d results outstanding", pending_positions.size());
        $display("tb: errors");
        $finish;
    end

    initial begin
        reset_shaper_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_coefficients();
        test_delay_range();
        test_input_pressure();
        test_random_phases();
        test_full_scale_swings();
        quiesce();
        $display("summary: %0d requests, %0d results checked, %0d saturated, %0d reg writes",
                 sent_count, result_count, sat_count, cfg_count);
        $display("summary: gain/delay extremes, output hold-off, full-scale delta swings");
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
